[rtl/fqr_pkg.sv]
package fqr_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_REPL = 2'd2,
    OP_CLR  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // control states
  typedef enum logic {
    ST_IDLE,
    ST_REPL
  } state_t;

endpackage

[rtl/fifo_queue_with_replace.sv]
// Timing: enqueue, dequeue, clear and replace on an empty queue give their result in the
//   cycle after the item is accepted; replace on a non-empty queue gives it after the walk.
// Throughput: one item per cycle while the output is free; replace stalls input while it
//   walks one entry per cycle through the single read port and write port of the memory.
// Reset (synchronous, rst_n low): head, count, state and output valid are cleared;
//   the entry memory is not cleared.
module fifo_queue_with_replace #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [DATA_WIDTH-1:0]          in_value,
  input  logic [DATA_WIDTH-1:0]          in_match_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [DATA_WIDTH-1:0]          out_data,
  output logic [1:0]                     out_status,
  output logic [$clog2(DEPTH+1)-1:0]     out_count,
  output logic                           out_empty_res,
  output logic                           out_full_res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_SW = SW'(DEPTH);

  // entry memory with registered read
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // control and walk state
  fqr_pkg::state_t       state_r, state_nxt;
  logic [IW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] repl_val_r, repl_val_nxt;
  logic [DATA_WIDTH-1:0] repl_match_r, repl_match_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  fqr_pkg::status_t      out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic                  out_free;
  logic                  in_acc;
  logic                  out_load;
  logic [SW-1:0]         tail_sum;
  logic [IW-1:0]         tail_idx;
  logic [IW-1:0]         head_inc;
  logic [IW-1:0]         ptr_inc;
  fqr_pkg::op_t          op;

  // circular index arithmetic
  always_comb begin
    head_inc = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
    ptr_inc  = (ptr_r == LAST_IDX) ? '0 : ptr_r + IW'(1);
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= DEPTH_SW) begin
      tail_sum = tail_sum - DEPTH_SW;
    end
    tail_idx = tail_sum[IW-1:0];
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == fqr_pkg::ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign op       = fqr_pkg::op_t'(in_op);

  // next state and memory access control
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    repl_val_nxt   = repl_val_r;
    repl_match_nxt = repl_match_r;
    wr_en          = 1'b0;
    wr_addr        = tail_idx;
    wr_data        = in_value;
    rd_addr        = head_r;
    out_load       = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = fqr_pkg::STAT_OK;

    unique case (state_r)
      fqr_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (op)
            fqr_pkg::OP_ENQ: begin
              if (count_r == FULL_CNT) begin
                out_status_nxt = fqr_pkg::STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            fqr_pkg::OP_DEQ: begin
              if (count_r == '0) begin
                out_status_nxt = fqr_pkg::STAT_EMPTY;
              end else begin
                out_data_nxt = rd_data_r;
                head_nxt     = head_inc;
                count_nxt    = count_r - CW'(1);
              end
            end
            fqr_pkg::OP_REPL: begin
              // walk only a non-empty queue, result comes at the end
              if (count_r != '0) begin
                out_load       = 1'b0;
                state_nxt      = fqr_pkg::ST_REPL;
                ptr_nxt        = head_r;
                rem_nxt        = count_r;
                repl_val_nxt   = in_value;
                repl_match_nxt = in_match_value;
              end
            end
            fqr_pkg::OP_CLR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
        // keep the front word prefetched
        rd_addr = head_nxt;
      end
      fqr_pkg::ST_REPL: begin
        // rd_data_r holds the entry at ptr_r
        wr_en   = (rd_data_r == repl_match_r);
        wr_addr = ptr_r;
        wr_data = repl_val_r;
        ptr_nxt = ptr_inc;
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          rd_addr   = head_r;
          state_nxt = fqr_pkg::ST_IDLE;
          out_load  = 1'b1;
        end else begin
          rd_addr = ptr_inc;
        end
      end
      default: ;
    endcase

    out_count_nxt = count_nxt;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // memory write and read with write forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqr_pkg::ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    repl_val_r   <= repl_val_nxt;
    repl_match_r <= repl_match_nxt;
    if (out_load) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_empty_res = (out_count_r == '0);
  assign out_full_res  = (out_count_r == FULL_CNT);

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("held count above capacity");

  // no result is pending while a replace walk runs
  a_walk_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqr_pkg::ST_REPL) |-> !out_valid_r)
    else $error("result pending during replace walk");

  // a successful dequeue removes exactly one word
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (op == fqr_pkg::OP_DEQ) && (count_r != '0))
      |=> (count_r == $past(count_r) - CW'(1)))
    else $error("dequeue count mismatch");

  // head stays inside the storage
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LAST_IDX)
    else $error("head index out of range");

endmodule
